>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> rtl/core/ehs_pkg.sv
// Types, constants and decode functions for the Ethernet header statistics block.
package ehs_pkg;

    localparam int MAC_W     = 48;
    localparam int TL_W      = 16;
    localparam int LEN_W     = 16;
    localparam int OUT_CNT_W = 32;
    localparam int PROTO_KINDS = 6;

    localparam logic [TL_W-1:0]  ETH_II_MIN      = 16'd1536;
    localparam logic [LEN_W-1:0] HEADER_OVERHEAD = 16'd18;
    localparam logic [MAC_W-1:0] MAC_BROADCAST   = {MAC_W{1'b1}};
    localparam int               GROUP_BIT       = 40;

    localparam logic [TL_W-1:0] ETYPE_ARP     = 16'h0806;
    localparam logic [TL_W-1:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [TL_W-1:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [TL_W-1:0] ETYPE_FLOWCTL = 16'h8808;
    localparam logic [TL_W-1:0] ETYPE_MACSEC  = 16'h88E5;

    typedef enum logic [1:0] {
        KIND_UNICAST   = 2'd0,
        KIND_MULTICAST = 2'd1,
        KIND_BROADCAST = 2'd2,
        KIND_NONE      = 2'd3
    } addr_kind_t;

    typedef enum logic [2:0] {
        PROTO_ARP     = 3'd0,
        PROTO_IPV4    = 3'd1,
        PROTO_IPV6    = 3'd2,
        PROTO_FLOWCTL = 3'd3,
        PROTO_MACSEC  = 3'd4,
        PROTO_OTHER   = 3'd5,
        PROTO_NONE    = 3'd6
    } proto_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup_init;
        logic key_src;
        logic finish;
    } ehs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eth_ii;
        logic lookup_done;
    } ehs_status_t;

    function automatic addr_kind_t addr_kind(input logic [MAC_W-1:0] mac);
        addr_kind_t k;
        if (mac == MAC_BROADCAST)
            k = KIND_BROADCAST;
        else if (mac[GROUP_BIT])
            k = KIND_MULTICAST;
        else
            k = KIND_UNICAST;
        return k;
    endfunction

    function automatic proto_kind_t proto_kind(input logic [TL_W-1:0] tl);
        proto_kind_t k;
        case (tl)
            ETYPE_ARP:     k = PROTO_ARP;
            ETYPE_IPV4:    k = PROTO_IPV4;
            ETYPE_IPV6:    k = PROTO_IPV6;
            ETYPE_FLOWCTL: k = PROTO_FLOWCTL;
            ETYPE_MACSEC:  k = PROTO_MACSEC;
            default:       k = PROTO_OTHER;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/core/ehs_datapath.sv
// Datapath: header capture, address table with its scan, counters and result registers.
module ehs_datapath
    import ehs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int COUNT_WIDTH   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ehs_cmd_t              cmd,
    output ehs_status_t           status,
    input  logic [MAC_W-1:0]      dest_mac,
    input  logic [MAC_W-1:0]      src_mac,
    input  logic [TL_W-1:0]       type_length,
    input  logic [LEN_W-1:0]      frame_length,
    output logic                  done,
    output logic                  is_ethernet_ii,
    output logic [1:0]            dest_kind,
    output logic [1:0]            src_kind,
    output logic [2:0]            protocol_kind,
    output logic [OUT_CNT_W-1:0]  protocol_count,
    output logic [OUT_CNT_W-1:0]  dest_seen,
    output logic [OUT_CNT_W-1:0]  src_seen,
    output logic                  table_full,
    output logic [OUT_CNT_W-1:0]  frame_number,
    output logic [OUT_CNT_W-1:0]  ethernet_ii_total,
    output logic [LEN_W-1:0]      payload_bytes
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int FILL_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = MAC_W + COUNT_WIDTH;
    localparam logic [FILL_W-1:0]      FILL_MAX = FILL_W'(TABLE_ENTRIES);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    // Each entry holds the address above its occurrence count.
    logic [ENTRY_W-1:0]     mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]     mem_q_reg;

    logic [MAC_W-1:0]       dmac_reg;
    logic [MAC_W-1:0]       smac_reg;
    logic [TL_W-1:0]        tl_reg;
    logic [LEN_W-1:0]       flen_reg;

    logic                   key_src_reg;
    logic                   active_reg;
    logic                   rd_pend_reg;
    logic                   lookup_done_reg;
    logic                   full_reg;
    logic [FILL_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [FILL_W-1:0]      used_reg;
    logic [COUNT_WIDTH-1:0] dst_seen_reg;
    logic [COUNT_WIDTH-1:0] src_cnt_reg;

    logic [COUNT_WIDTH-1:0] proto_cnt_reg [PROTO_KINDS];
    logic [COUNT_WIDTH-1:0] eth2_cnt_reg;
    logic [COUNT_WIDTH-1:0] frame_cnt_reg;

    logic                   done_reg;
    logic                   is_eth_reg;
    addr_kind_t             dest_kind_reg;
    addr_kind_t             src_kind_reg;
    proto_kind_t            proto_kind_reg;
    logic [OUT_CNT_W-1:0]   proto_count_reg;
    logic [OUT_CNT_W-1:0]   dest_seen_reg;
    logic [OUT_CNT_W-1:0]   src_seen_reg;
    logic                   table_full_reg;
    logic [OUT_CNT_W-1:0]   frame_number_reg;
    logic [OUT_CNT_W-1:0]   eth2_total_reg;
    logic [LEN_W-1:0]       payload_reg;

    logic [MAC_W-1:0]       key;
    logic [MAC_W-1:0]       q_mac;
    logic [COUNT_WIDTH-1:0] q_cnt;
    logic [COUNT_WIDTH-1:0] q_inc;
    logic                   hit;
    logic                   more;
    logic                   rd_en;
    logic                   exhausted;
    logic                   room;
    logic                   lookup_end;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [COUNT_WIDTH-1:0] seen_val;
    logic                   eth_ii;
    proto_kind_t            pk;
    logic [COUNT_WIDTH-1:0] proto_next;
    logic [COUNT_WIDTH-1:0] eth2_next;

    // Valid entries always occupy the lowest places, so the fill count marks them.
    assign key        = key_src_reg ? smac_reg : dmac_reg;
    assign q_mac      = mem_q_reg[ENTRY_W-1:COUNT_WIDTH];
    assign q_cnt      = mem_q_reg[COUNT_WIDTH-1:0];
    assign q_inc      = sat_inc(q_cnt);
    assign hit        = active_reg && rd_pend_reg && (q_mac == key);
    assign more       = rd_idx_reg < used_reg;
    assign rd_en      = active_reg && !hit && more;
    assign exhausted  = active_reg && !rd_pend_reg && !more;
    assign room       = used_reg != FILL_MAX;
    assign lookup_end = hit || exhausted;
    assign wr_en      = hit || (exhausted && room);
    assign wr_addr    = hit ? cmp_idx_reg : used_reg[IDX_W-1:0];
    assign wr_data    = {key, (hit ? q_inc : CNT_ONE)};
    assign seen_val   = hit ? q_inc : (room ? CNT_ONE : '0);

    assign eth_ii     = tl_reg >= ETH_II_MIN;
    assign pk         = proto_kind(tl_reg);
    assign proto_next = sat_inc(proto_cnt_reg[pk]);
    assign eth2_next  = sat_inc(eth2_cnt_reg);

    assign status.eth_ii      = eth_ii;
    assign status.lookup_done = lookup_done_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dmac_reg <= dest_mac;
            smac_reg <= src_mac;
            tl_reg   <= type_length;
            flen_reg <= frame_length;
        end
        if (lookup_end)
        begin
            if (key_src_reg)
                src_cnt_reg <= seen_val;
            else
                dst_seen_reg <= seen_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_src_reg     <= 1'b0;
            active_reg      <= 1'b0;
            rd_pend_reg     <= 1'b0;
            lookup_done_reg <= 1'b0;
            full_reg        <= 1'b0;
            rd_idx_reg      <= '0;
            cmp_idx_reg     <= '0;
            used_reg        <= '0;
        end
        else
        begin
            lookup_done_reg <= lookup_end;
            if (cmd.load)
                full_reg <= 1'b0;
            if (cmd.lookup_init)
            begin
                active_reg  <= 1'b1;
                rd_pend_reg <= 1'b0;
                rd_idx_reg  <= '0;
                key_src_reg <= cmd.key_src;
            end
            else if (active_reg)
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg  <= rd_idx_reg + FILL_W'(1);
                    cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
                end
                if (lookup_end)
                    active_reg <= 1'b0;
                if (exhausted && room)
                    used_reg <= used_reg + FILL_W'(1);
                if (exhausted && !room)
                    full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PROTO_KINDS; i++)
                proto_cnt_reg[i] <= '0;
            eth2_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                frame_cnt_reg <= sat_inc(frame_cnt_reg);
                if (eth_ii)
                begin
                    eth2_cnt_reg      <= eth2_next;
                    proto_cnt_reg[pk] <= proto_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            frame_number_reg <= OUT_CNT_W'(frame_cnt_reg);
            if (eth_ii)
            begin
                is_eth_reg       <= 1'b1;
                dest_kind_reg    <= addr_kind(dmac_reg);
                src_kind_reg     <= addr_kind(smac_reg);
                proto_kind_reg   <= pk;
                proto_count_reg  <= OUT_CNT_W'(proto_next);
                dest_seen_reg    <= OUT_CNT_W'(dst_seen_reg);
                src_seen_reg     <= OUT_CNT_W'(src_cnt_reg);
                table_full_reg   <= full_reg;
                eth2_total_reg   <= OUT_CNT_W'(eth2_next);
                payload_reg      <= (flen_reg >= HEADER_OVERHEAD) ?
                                    flen_reg - HEADER_OVERHEAD : '0;
            end
            else
            begin
                is_eth_reg       <= 1'b0;
                dest_kind_reg    <= KIND_NONE;
                src_kind_reg     <= KIND_NONE;
                proto_kind_reg   <= PROTO_NONE;
                proto_count_reg  <= '0;
                dest_seen_reg    <= '0;
                src_seen_reg     <= '0;
                table_full_reg   <= 1'b0;
                eth2_total_reg   <= OUT_CNT_W'(eth2_cnt_reg);
                payload_reg      <= '0;
            end
        end
    end

    assign done              = done_reg;
    assign is_ethernet_ii    = is_eth_reg;
    assign dest_kind         = dest_kind_reg;
    assign src_kind          = src_kind_reg;
    assign protocol_kind     = proto_kind_reg;
    assign protocol_count    = proto_count_reg;
    assign dest_seen         = dest_seen_reg;
    assign src_seen          = src_seen_reg;
    assign table_full        = table_full_reg;
    assign frame_number      = frame_number_reg;
    assign ethernet_ii_total = eth2_total_reg;
    assign payload_bytes     = payload_reg;

endmodule

>>> rtl/core/ehs_controller.sv
// Controller: sequences header capture, the two address lookups and the result update.
module ehs_controller
    import ehs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output ehs_cmd_t    cmd,
    input  ehs_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DST_WAIT,
        S_SRC_INIT,
        S_SRC_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = status.eth_ii ? S_DST_WAIT : S_FINISH;
            S_DST_WAIT:
                if (status.lookup_done)
                    state_next = S_SRC_INIT;
            S_SRC_INIT:
                state_next = S_SRC_WAIT;
            S_SRC_WAIT:
                if (status.lookup_done)
                    state_next = S_FINISH;
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
        end
    end

    // The destination is looked up first so that a source equal to it counts the same entry.
    assign cmd.load        = start && !busy_reg;
    assign cmd.lookup_init = ((state_reg == S_CHECK) && status.eth_ii) ||
                             (state_reg == S_SRC_INIT);
    assign cmd.key_src     = state_reg == S_SRC_INIT;
    assign cmd.finish      = state_reg == S_FINISH;
    assign busy            = busy_reg;

endmodule

>>> rtl/core/ethernet_header_statistics.sv
// Top level of the Ethernet header statistics block.
//
//  Channel   Handshake           Fields
//  -------   ------------------  --------------------------------------------------
//  header    start / busy        dest_mac, src_mac, type_length, frame_length
//  result    done (one cycle)    is_ethernet_ii, dest_kind, src_kind, protocol_kind,
//                                protocol_count, dest_seen, src_seen, table_full,
//                                frame_number, ethernet_ii_total, payload_bytes
//
// A header is transferred when start is high and busy is low; one header is in work at a time.
// An IEEE 802.3 frame goes from the transfer through the check and finish states to its
// result. An Ethernet II frame scans the address table once per address at one stored
// entry a cycle, over no more than the addresses held, bounded by TABLE_ENTRIES; a match
// ends a scan early. The next header can be transferred as the result leaves.
// The table is a single-port-write memory; a fill count marks valid entries, so no
// clearing pass follows reset. Reset clears all counters and leaves the block idle.
// Each result is shown for exactly one cycle with done; the receiver cannot stall it.
module ethernet_header_statistics
    import ehs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int COUNT_WIDTH   = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MAC_W-1:0]      dest_mac,
    input  logic [MAC_W-1:0]      src_mac,
    input  logic [TL_W-1:0]       type_length,
    input  logic [LEN_W-1:0]      frame_length,
    output logic                  done,
    output logic                  is_ethernet_ii,
    output logic [1:0]            dest_kind,
    output logic [1:0]            src_kind,
    output logic [2:0]            protocol_kind,
    output logic [OUT_CNT_W-1:0]  protocol_count,
    output logic [OUT_CNT_W-1:0]  dest_seen,
    output logic [OUT_CNT_W-1:0]  src_seen,
    output logic                  table_full,
    output logic [OUT_CNT_W-1:0]  frame_number,
    output logic [OUT_CNT_W-1:0]  ethernet_ii_total,
    output logic [LEN_W-1:0]      payload_bytes
);

    ehs_cmd_t    cmd;
    ehs_status_t status;

    ehs_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    ehs_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .dest_mac          (dest_mac),
        .src_mac           (src_mac),
        .type_length       (type_length),
        .frame_length      (frame_length),
        .done              (done),
        .is_ethernet_ii    (is_ethernet_ii),
        .dest_kind         (dest_kind),
        .src_kind          (src_kind),
        .protocol_kind     (protocol_kind),
        .protocol_count    (protocol_count),
        .dest_seen         (dest_seen),
        .src_seen          (src_seen),
        .table_full        (table_full),
        .frame_number      (frame_number),
        .ethernet_ii_total (ethernet_ii_total),
        .payload_bytes     (payload_bytes)
    );

endmodule

>>> rtl/core/ehs_checker.sv
// Port-level checker for the Ethernet header statistics block, with its bind.
`include "assert_macros.svh"

module ehs_checker
    import ehs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             is_ethernet_ii,
    input logic [1:0]       dest_kind,
    input logic [1:0]       src_kind,
    input logic [2:0]       protocol_kind,
    input logic [LEN_W-1:0] payload_bytes
);

    `ASSERT_NEXT(a_transfer_sets_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_done_when_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLY(a_plain_8023_result, clk, rst_n, done && !is_ethernet_ii, (dest_kind == KIND_NONE) && (src_kind == KIND_NONE) && (protocol_kind == PROTO_NONE) && (payload_bytes == '0))
    `ASSERT_IMPLY(a_eth_ii_classified, clk, rst_n, done && is_ethernet_ii, (dest_kind != KIND_NONE) && (src_kind != KIND_NONE) && (protocol_kind != PROTO_NONE))

endmodule

bind ethernet_header_statistics ehs_checker u_ehs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .is_ethernet_ii (is_ethernet_ii),
    .dest_kind      (dest_kind),
    .src_kind       (src_kind),
    .protocol_kind  (protocol_kind),
    .payload_bytes  (payload_bytes)
);

>>> sim/tb_ethernet_header_statistics.sv
// Self-checking testbench for the Ethernet header statistics block.
module tb_ethernet_header_statistics;
    import ehs_pkg::*;

    localparam int TABLE_DEPTH    = 32;
    localparam int RANDOM_HEADERS = 625;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] src_mac;
        logic [TL_W-1:0]  type_length;
        logic [LEN_W-1:0] frame_length;
    } header_t;

    typedef struct {
        logic                 is_ethernet_ii;
        addr_kind_t           dest_kind;
        addr_kind_t           src_kind;
        proto_kind_t          protocol_kind;
        logic [OUT_CNT_W-1:0] protocol_count;
        logic [OUT_CNT_W-1:0] dest_seen;
        logic [OUT_CNT_W-1:0] src_seen;
        logic                 table_full;
        logic [OUT_CNT_W-1:0] frame_number;
        logic [OUT_CNT_W-1:0] ethernet_ii_total;
        logic [LEN_W-1:0]     payload_bytes;
    } frame_stats_t;

    class header_scoreboard;
        logic [MAC_W-1:0]     mac_table [TABLE_DEPTH];
        logic [OUT_CNT_W-1:0] mac_hits [TABLE_DEPTH];
        bit                   mac_used [TABLE_DEPTH];
        logic [OUT_CNT_W-1:0] proto_tally [PROTO_KINDS];
        logic [OUT_CNT_W-1:0] eth2_tally;
        logic [OUT_CNT_W-1:0] frame_tally;
        frame_stats_t         expected_q [$];
        int                   failures;
        int                   checked;
        int                   eth2_frames;
        int                   full_frames;

        function new();
            foreach (mac_table[i])
            begin
                mac_table[i] = '0;
                mac_hits[i]  = '0;
                mac_used[i]  = 1'b0;
            end
            foreach (proto_tally[k])
                proto_tally[k] = '0;
            eth2_tally  = '0;
            frame_tally = '0;
            failures    = 0;
            checked     = 0;
            eth2_frames = 0;
            full_frames = 0;
        endfunction

        function logic [OUT_CNT_W-1:0] bump(logic [OUT_CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function addr_kind_t classify_mac(logic [MAC_W-1:0] mac);
            if (mac == MAC_BROADCAST)
                return KIND_BROADCAST;
            if (mac[GROUP_BIT])
                return KIND_MULTICAST;
            return KIND_UNICAST;
        endfunction

        function proto_kind_t decode_ethertype(logic [TL_W-1:0] tl);
            case (tl)
                ETYPE_ARP:     return PROTO_ARP;
                ETYPE_IPV4:    return PROTO_IPV4;
                ETYPE_IPV6:    return PROTO_IPV6;
                ETYPE_FLOWCTL: return PROTO_FLOWCTL;
                ETYPE_MACSEC:  return PROTO_MACSEC;
                default:       return PROTO_OTHER;
            endcase
        endfunction

        // Looks the address up, else claims the first free entry; zero when none is left.
        function logic [OUT_CNT_W-1:0] tally_mac(logic [MAC_W-1:0] mac, inout bit full);
            int slot;
            slot = -1;
            foreach (mac_table[i])
                if (slot < 0 && mac_used[i] && mac_table[i] == mac)
                    slot = i;
            if (slot >= 0)
            begin
                mac_hits[slot] = bump(mac_hits[slot]);
                return mac_hits[slot];
            end
            foreach (mac_used[i])
                if (slot < 0 && !mac_used[i])
                    slot = i;
            if (slot < 0)
            begin
                full = 1'b1;
                return '0;
            end
            mac_used[slot]  = 1'b1;
            mac_table[slot] = mac;
            mac_hits[slot]  = OUT_CNT_W'(1);
            return OUT_CNT_W'(1);
        endfunction

        function void note_header(header_t h);
            frame_stats_t s;
            proto_kind_t  pk;
            bit           full;
            full               = 1'b0;
            s.is_ethernet_ii   = 1'b0;
            s.dest_kind        = KIND_NONE;
            s.src_kind         = KIND_NONE;
            s.protocol_kind    = PROTO_NONE;
            s.protocol_count   = '0;
            s.dest_seen        = '0;
            s.src_seen         = '0;
            s.table_full       = 1'b0;
            s.payload_bytes    = '0;
            s.frame_number     = frame_tally;
            if (h.type_length >= ETH_II_MIN)
            begin
                eth2_tally         = bump(eth2_tally);
                s.is_ethernet_ii   = 1'b1;
                s.dest_kind        = classify_mac(h.dest_mac);
                s.src_kind         = classify_mac(h.src_mac);
                // The destination is counted before the source, so a repeated
                // address that the table holds shows one more on the source side.
                s.dest_seen        = tally_mac(h.dest_mac, full);
                s.src_seen         = tally_mac(h.src_mac, full);
                pk                 = decode_ethertype(h.type_length);
                proto_tally[int'(pk)] = bump(proto_tally[int'(pk)]);
                s.protocol_kind    = pk;
                s.protocol_count   = proto_tally[int'(pk)];
                s.table_full       = full;
                if (h.frame_length >= HEADER_OVERHEAD)
                    s.payload_bytes = h.frame_length - HEADER_OVERHEAD;
                eth2_frames++;
                if (full)
                    full_frames++;
            end
            s.ethernet_ii_total = eth2_tally;
            frame_tally = bump(frame_tally);
            expected_q.push_back(s);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                failures++;
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(frame_stats_t got);
            frame_stats_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                $display("%0t: result with no header outstanding", $time);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare("is_ethernet_ii", want.is_ethernet_ii, got.is_ethernet_ii);
            compare("dest_kind", want.dest_kind, got.dest_kind);
            compare("src_kind", want.src_kind, got.src_kind);
            compare("protocol_kind", want.protocol_kind, got.protocol_kind);
            compare("protocol_count", want.protocol_count, got.protocol_count);
            compare("dest_seen", want.dest_seen, got.dest_seen);
            compare("src_seen", want.src_seen, got.src_seen);
            compare("table_full", want.table_full, got.table_full);
            compare("frame_number", want.frame_number, got.frame_number);
            compare("ethernet_ii_total", want.ethernet_ii_total, got.ethernet_ii_total);
            compare("payload_bytes", want.payload_bytes, got.payload_bytes);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [MAC_W-1:0]     dest_mac = '0;
    logic [MAC_W-1:0]     src_mac = '0;
    logic [TL_W-1:0]      type_length = '0;
    logic [LEN_W-1:0]     frame_length = '0;
    logic                 done;
    logic                 is_ethernet_ii;
    logic [1:0]           dest_kind;
    logic [1:0]           src_kind;
    logic [2:0]           protocol_kind;
    logic [OUT_CNT_W-1:0] protocol_count;
    logic [OUT_CNT_W-1:0] dest_seen;
    logic [OUT_CNT_W-1:0] src_seen;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] frame_number;
    logic [OUT_CNT_W-1:0] ethernet_ii_total;
    logic [LEN_W-1:0]     payload_bytes;

    header_scoreboard sb = new();
    int               idle_cycles = 0;
    bit               no_idle = 1'b0;

    ethernet_header_statistics #(
        .TABLE_ENTRIES (TABLE_DEPTH),
        .COUNT_WIDTH   (OUT_CNT_W)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .dest_mac          (dest_mac),
        .src_mac           (src_mac),
        .type_length       (type_length),
        .frame_length      (frame_length),
        .done              (done),
        .is_ethernet_ii    (is_ethernet_ii),
        .dest_kind         (dest_kind),
        .src_kind          (src_kind),
        .protocol_kind     (protocol_kind),
        .protocol_count    (protocol_count),
        .dest_seen         (dest_seen),
        .src_seen          (src_seen),
        .table_full        (table_full),
        .frame_number      (frame_number),
        .ethernet_ii_total (ethernet_ii_total),
        .payload_bytes     (payload_bytes)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // A result is checked before the transfer of the same edge is noted, as it
    // always belongs to an older header.
    always @(posedge clk)
    begin
        frame_stats_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.is_ethernet_ii    = is_ethernet_ii;
                got.dest_kind         = addr_kind_t'(dest_kind);
                got.src_kind          = addr_kind_t'(src_kind);
                got.protocol_kind     = proto_kind_t'(protocol_kind);
                got.protocol_count    = protocol_count;
                got.dest_seen         = dest_seen;
                got.src_seen          = src_seen;
                got.table_full        = table_full;
                got.frame_number      = frame_number;
                got.ethernet_ii_total = ethernet_ii_total;
                got.payload_bytes     = payload_bytes;
                sb.check_result(got);
            end
            if (start && !busy)
                sb.note_header('{dest_mac, src_mac, type_length, frame_length});
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_header(input header_t h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        dest_mac     <= h.dest_mac;
        src_mac      <= h.src_mac;
        type_length  <= h.type_length;
        frame_length <= h.frame_length;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Mostly addresses already held in the table, now and then one it cannot take.
    function automatic logic [MAC_W-1:0] pick_mac();
        int slot;
        slot = $urandom_range(0, TABLE_DEPTH + 3);
        if (slot >= TABLE_DEPTH)
            return {16'($urandom), 32'($urandom)};
        return sb.mac_table[slot];
    endfunction

    function automatic header_t random_header();
        header_t h;
        int      pick;
        h.dest_mac = pick_mac();
        h.src_mac  = ($urandom_range(0, 19) == 0) ? h.dest_mac : pick_mac();
        pick = $urandom_range(0, 99);
        if (pick < 20)
            h.type_length = 16'($urandom_range(0, ETH_II_MIN - 1));
        else if (pick < 35)
            h.type_length = 16'($urandom_range(ETH_II_MIN, 16'hFFFF));
        else
        begin
            case (pick % 5)
                0:       h.type_length = ETYPE_ARP;
                1:       h.type_length = ETYPE_IPV4;
                2:       h.type_length = ETYPE_IPV6;
                3:       h.type_length = ETYPE_FLOWCTL;
                default: h.type_length = ETYPE_MACSEC;
            endcase
        end
        pick = $urandom_range(0, 9);
        if (pick < 2)
            h.frame_length = 16'($urandom_range(0, 25));
        else if (pick < 8)
            h.frame_length = 16'($urandom_range(46, 1518));
        else
            h.frame_length = 16'($urandom);
        return h;
    endfunction

    initial
    begin
        int i;
        wait (rst_n);
        @(posedge clk);

        // IEEE 802.3 frames at both ends of the field ranges.
        send_header('{48'h0, 48'h0, 16'd0, 16'd0});
        send_header('{MAC_BROADCAST, MAC_BROADCAST, ETH_II_MIN - 16'd1, 16'hFFFF});
        // Lowest Ethernet II value, unknown ethertype and a short frame.
        send_header('{48'h0, 48'h0200_0000_0001, ETH_II_MIN, 16'd17});
        send_header('{MAC_BROADCAST, 48'h0200_0000_0001, ETYPE_ARP, HEADER_OVERHEAD});
        send_header('{48'h0100_5E00_0001, 48'h0200_0000_0002, ETYPE_IPV4, 16'd64});
        send_header('{48'h3333_0000_0001, 48'h0200_0000_0002, ETYPE_IPV6, 16'hFFFF});
        send_header('{48'h0180_C200_0001, 48'h0200_0000_0003, ETYPE_FLOWCTL, 16'd60});
        send_header('{48'h0200_0000_0003, 48'h0200_0000_0001, ETYPE_MACSEC, 16'd1518});
        // Same address in both positions.
        send_header('{48'h0200_0000_0004, 48'h0200_0000_0004, 16'hFFFF, 16'd19});
        send_header('{48'hFFFF_FFFF_FFFE, MAC_BROADCAST, ETYPE_IPV4, 16'd1500});
        send_header('{48'h0100_0000_0000, 48'hFEFF_FFFF_FFFF, ETYPE_IPV4, 16'd100});
        send_header('{48'h0200_0000_0001, 48'h0, ETYPE_ARP, 16'd46});
        send_header('{48'h0400_0000_0000, 48'h0200_0000_0001, 16'd1500, 16'd64});
        send_header('{48'h0200_0000_0004, 48'h0200_0000_0004, ETYPE_IPV6, 16'd0});
        // Fill the rest of the address table, then offer addresses it cannot hold.
        for (i = 0; i < 10; i++)
            send_header('{48'h0A00_0000_0000 + 48'(2 * i), 48'h0A00_0000_0001 + 48'(2 * i),
                          ETYPE_IPV4, 16'd64 + 16'(i)});
        send_header('{48'h0C00_0000_0001, 48'h0200_0000_0001, ETYPE_ARP, 16'd60});
        send_header('{48'h0C00_0000_0002, 48'h0D00_0000_0003, 16'h9000, 16'd80});

        for (i = 0; i < RANDOM_HEADERS; i++)
        begin
            // Every other stretch of 40 headers runs without idle cycles.
            no_idle = ((i / 40) % 2) == 1;
            if (i == RANDOM_HEADERS / 2)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            send_header(random_header());
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d headers: %0d Ethernet II, %0d with a full address table.",
                 sb.checked, sb.eth2_frames, sb.full_frames);
        $display("Directed limits and ethertypes, a filled table, then random traffic.");
        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
